/* rtl/tcgs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the 5x8 font table for the text cursor glyph streamer.
package tcgs_pkg;

  localparam logic [7:0] CMD_COL_WIN   = 8'h21;
  localparam logic [7:0] CMD_PAGE_WIN  = 8'h22;
  localparam logic [7:0] FIRST_PRINT   = 8'd32;
  localparam logic [7:0] LAST_PRINT    = 8'd126;
  localparam logic [7:0] CURSOR_ADV    = 8'd6;
  localparam logic [7:0] GLYPH_END_OFS = 8'd4;
  localparam logic [3:0] MAX_PAGES     = 4'd8;
  localparam int unsigned NUM_GLYPHS   = 95;

  localparam logic [6:0] RST_LAST_COL   = 7'd123;
  localparam logic [3:0] RST_PAGE_COUNT = 4'd8;
  localparam logic       RST_WRAP       = 1'b1;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_PRINT      = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_WRAP_ENABLE = 2'd0,
    CFG_LAST_COL    = 2'd1,
    CFG_PAGE_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    STEP_COL_CMD    = 4'd0,
    STEP_COL_START  = 4'd1,
    STEP_COL_END    = 4'd2,
    STEP_PAGE_CMD   = 4'd3,
    STEP_PAGE_START = 4'd4,
    STEP_PAGE_END   = 4'd5,
    STEP_GLYPH0     = 4'd6,
    STEP_GLYPH1     = 4'd7,
    STEP_GLYPH2     = 4'd8,
    STEP_GLYPH3     = 4'd9,
    STEP_GLYPH4     = 4'd10
  } step_e;

  // One character run: window origin and the five glyph columns, first column in the top byte.
  typedef struct packed {
    logic [6:0]  col;
    logic [2:0]  page;
    logic [39:0] glyph;
  } glyph_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [39:0] GLYPH_ROM [NUM_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649562050, 40'h0008070300, 40'h001C224100, 40'h0041221C00,
    40'h2A1C7F1C2A, 40'h08083E0808, 40'h0080703000, 40'h0808080808, 40'h0000606000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907, 40'h3649494936,
    40'h464949291E, 40'h0000140000, 40'h0040340000, 40'h0008142241, 40'h1414141414,
    40'h0041221408, 40'h0201590906, 40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h2649494932, 40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
    40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040, 40'h0003070800,
    40'h2054547840, 40'h7F28444438, 40'h3844444428, 40'h384444287F, 40'h3854545418,
    40'h00087E0902, 40'h18A4A49C78, 40'h7F08040478, 40'h00447D4000, 40'h2040403D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424, 40'h04043F4424,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h4C9090907C,
    40'h4464544C44, 40'h0008364100, 40'h0000770000, 40'h0041360800, 40'h0201020402
  };

endpackage

/* rtl/tcgs_front.sv */
`timescale 1ns / 1ps
// Front end: configuration, text cursor, item classification and job issue.
module tcgs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [6:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [7:0]            char_code_i,
  input  logic [7:0]            new_column_i,
  input  logic [7:0]            new_page_i,
  input  tcgs_pkg::q_stat_t     q_stat_i,
  output logic                  q_push_o,
  output tcgs_pkg::glyph_job_t  q_wdata_o
);

  logic       wrap_q, wrap_d;
  logic [6:0] last_col_q, last_col_d;
  logic [3:0] page_cnt_q, page_cnt_d;
  logic [6:0] cursor_col_q, cursor_col_d;
  logic [2:0] cursor_page_q, cursor_page_d;

  logic       in_fire;
  logic [3:0] pages;
  logic       set_ok;
  logic       cur_ok;
  logic       printable;
  logic [7:0] col_sum;
  logic [3:0] page_inc;
  logic [2:0] page_next;
  logic [6:0] glyph_idx;

  assign in_ready_o = !q_stat_i.full;
  assign in_fire    = in_valid_i && in_ready_o;

  // Page counts above eight saturate to the depth of the page state.
  assign pages = (page_cnt_q > tcgs_pkg::MAX_PAGES) ? tcgs_pkg::MAX_PAGES : page_cnt_q;

  assign set_ok    = (new_column_i <= {1'b0, last_col_q}) && (new_page_i < {4'b0000, pages});
  assign cur_ok    = (cursor_col_q <= last_col_q) && ({1'b0, cursor_page_q} < pages);
  assign printable = char_code_i inside {[tcgs_pkg::FIRST_PRINT:tcgs_pkg::LAST_PRINT]};

  assign col_sum   = {1'b0, cursor_col_q} + tcgs_pkg::CURSOR_ADV;
  assign page_inc  = {1'b0, cursor_page_q} + 4'd1;
  assign page_next = (page_inc == pages) ? 3'd0 : page_inc[2:0];

  assign glyph_idx = char_code_i[6:0] - tcgs_pkg::FIRST_PRINT[6:0];

  assign q_push_o = in_fire && (operation_i == tcgs_pkg::OP_PRINT) && cur_ok && printable;

  always_comb begin
    q_wdata_o.col   = cursor_col_q;
    q_wdata_o.page  = cursor_page_q;
    q_wdata_o.glyph = tcgs_pkg::GLYPH_ROM[glyph_idx];
  end

  always_comb begin
    wrap_d     = wrap_q;
    last_col_d = last_col_q;
    page_cnt_d = page_cnt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tcgs_pkg::CFG_WRAP_ENABLE: wrap_d     = cfg_data_i[0];
        tcgs_pkg::CFG_LAST_COL:    last_col_d = cfg_data_i;
        tcgs_pkg::CFG_PAGE_COUNT:  page_cnt_d = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cursor_col_d  = cursor_col_q;
    cursor_page_d = cursor_page_q;
    if (in_fire && (operation_i == tcgs_pkg::OP_SET_CURSOR) && set_ok) begin
      cursor_col_d  = new_column_i[6:0];
      cursor_page_d = new_page_i[2:0];
    end else if (q_push_o) begin
      // Advance past the glyph and its spacing column; return to the line start at the end.
      if (col_sum > {1'b0, last_col_q}) begin
        cursor_col_d = 7'd0;
        if (wrap_q) begin
          cursor_page_d = page_next;
        end
      end else begin
        cursor_col_d = col_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q        <= tcgs_pkg::RST_WRAP;
      last_col_q    <= tcgs_pkg::RST_LAST_COL;
      page_cnt_q    <= tcgs_pkg::RST_PAGE_COUNT;
      cursor_col_q  <= 7'd0;
      cursor_page_q <= 3'd0;
    end else begin
      wrap_q        <= wrap_d;
      last_col_q    <= last_col_d;
      page_cnt_q    <= page_cnt_d;
      cursor_col_q  <= cursor_col_d;
      cursor_page_q <= cursor_page_d;
    end
  end

  a_cursor_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(cursor_col_q) && $stable(cursor_page_q))
    else $error("cursor moved without a transaction");

  a_cursor_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> (cursor_col_q == 7'd0) || (cursor_col_q == $past(cursor_col_q) + 7'd6))
    else $error("cursor column did not advance by one glyph cell");

endmodule

/* rtl/tcgs_fifo.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the byte sequencer.
module tcgs_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcgs_pkg::glyph_job_t  wdata_i,
  input  logic                  pop_i,
  output tcgs_pkg::glyph_job_t  rdata_o,
  output tcgs_pkg::q_stat_t     stat_o
);

  tcgs_pkg::glyph_job_t mem_q [tcgs_pkg::Q_DEPTH];

  logic [tcgs_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tcgs_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tcgs_pkg::Q_CNT_W-1:0] count_q, count_d;

  localparam logic [tcgs_pkg::Q_PTR_W-1:0] PtrLast = tcgs_pkg::Q_PTR_W'(tcgs_pkg::Q_DEPTH - 1);
  localparam logic [tcgs_pkg::Q_CNT_W-1:0] CntFull = tcgs_pkg::Q_CNT_W'(tcgs_pkg::Q_DEPTH);

  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("job queue underflow");

endmodule

/* rtl/tcgs_back.sv */
`timescale 1ns / 1ps
// Back end: walks one queued job through its eleven output bytes into an output register.
module tcgs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcgs_pkg::q_stat_t     q_stat_i,
  input  tcgs_pkg::glyph_job_t  q_rdata_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  is_data_o,
  output logic                  last_o
);

  tcgs_pkg::step_e step_q, step_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       is_data_q;
  logic       last_q;

  logic       advance;
  logic       is_last_step;
  logic [7:0] byte_sel;
  logic       data_sel;

  // Load a new byte whenever a job is queued and the output register is empty or being drained.
  assign advance      = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign is_last_step = (step_q == tcgs_pkg::STEP_GLYPH4);
  assign q_pop_o      = advance && is_last_step;

  always_comb begin
    byte_sel = 8'h00;
    data_sel = 1'b1;
    case (step_q)
      tcgs_pkg::STEP_COL_CMD: begin
        byte_sel = tcgs_pkg::CMD_COL_WIN;
        data_sel = 1'b0;
      end
      tcgs_pkg::STEP_COL_START: begin
        byte_sel = {1'b0, q_rdata_i.col};
        data_sel = 1'b0;
      end
      tcgs_pkg::STEP_COL_END: begin
        byte_sel = {1'b0, q_rdata_i.col} + tcgs_pkg::GLYPH_END_OFS;
        data_sel = 1'b0;
      end
      tcgs_pkg::STEP_PAGE_CMD: begin
        byte_sel = tcgs_pkg::CMD_PAGE_WIN;
        data_sel = 1'b0;
      end
      tcgs_pkg::STEP_PAGE_START,
      tcgs_pkg::STEP_PAGE_END: begin
        byte_sel = {5'b00000, q_rdata_i.page};
        data_sel = 1'b0;
      end
      tcgs_pkg::STEP_GLYPH0: byte_sel = q_rdata_i.glyph[39:32];
      tcgs_pkg::STEP_GLYPH1: byte_sel = q_rdata_i.glyph[31:24];
      tcgs_pkg::STEP_GLYPH2: byte_sel = q_rdata_i.glyph[23:16];
      tcgs_pkg::STEP_GLYPH3: byte_sel = q_rdata_i.glyph[15:8];
      tcgs_pkg::STEP_GLYPH4: byte_sel = q_rdata_i.glyph[7:0];
      default: begin
        byte_sel = 8'h00;
        data_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (advance) begin
      step_d = is_last_step ? tcgs_pkg::STEP_COL_CMD : tcgs_pkg::step_e'(step_q + 4'd1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= tcgs_pkg::STEP_COL_CMD;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_sel;
      is_data_q  <= data_sel;
      last_q     <= is_last_step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

  a_pop_on_final_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> out_valid_q && last_q && is_data_q && (step_q == tcgs_pkg::STEP_COL_CMD))
    else $error("job retired without its final glyph byte");

endmodule

/* rtl/text_cursor_glyph_streamer.sv */
`timescale 1ns / 1ps
// Top level of the text cursor glyph streamer: front end, job queue and byte sequencer.
// A printable character (codes 32 to 126) at an in-range cursor produces eleven output
// transactions, one per clock while the sink is ready: the column window command (0x21,
// column, column + 4), the page window command (0x22, page, page) and five font columns,
// the last one flagged by last_o. The byte sequencer emits one byte per cycle while the
// sink is ready, and a queued next character's first byte follows the previous one's
// last byte without a gap. Set-cursor items, and characters that are dropped, produce
// nothing. The front end updates the cursor as it accepts each item; the job queue holds
// up to two characters, including the one whose bytes are being emitted. There is no
// start-up sweep after reset; the user must write configuration only while the block
// is idle, and the block itself does not enforce it.
module text_cursor_glyph_streamer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] new_column_i,
  input  logic [7:0] new_page_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  tcgs_pkg::q_stat_t    q_stat;
  tcgs_pkg::glyph_job_t q_wdata;
  tcgs_pkg::glyph_job_t q_rdata;
  logic                 q_push;
  logic                 q_pop;

  tcgs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .new_column_i (new_column_i),
    .new_page_i   (new_page_i),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata)
  );

  tcgs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  tcgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

endmodule
